### hw/rtl/vdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared types and constants of the voxel dose tally: item layouts, status
// codes, register indexes and the fixed scaling constants.
// ----------------------------------------------------------------------------
package vdt_pkg;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOXELS_X     = 2'd0,
    REG_VOXELS_Y     = 2'd1,
    REG_VOXELS_Z     = 2'd2,
    REG_VOXEL_VOLUME = 2'd3
  } cfg_reg_t;

  localparam logic [6:0]  VOXELS_RST = 7'd64;
  localparam logic [31:0] VOLUME_RST = 32'd1000000;

  // item function codes
  localparam logic FUNC_DEPOSIT = 1'b0;
  localparam logic FUNC_READOUT = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_RANGE   = 3'd2,
    ST_NO_MASS = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  // 100 percent in Q8.8 squared is 10000 << 16
  localparam logic [47:0] RSD_SCALE = 48'd10000;
  localparam int          RSD_SHIFT = 16;

  typedef struct packed {
    logic        func;
    logic [5:0]  x_index;
    logic [5:0]  y_index;
    logic [5:0]  z_index;
    logic        in_scoring_volume;
    logic [31:0] energy_ev;
    logic [15:0] density;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [47:0] dose_sum;
    logic [63:0] dose_square_sum;
    logic [31:0] hit_count;
    logic [15:0] relative_deviation;
    logic        deviation_valid;
  } out_item_t;

  // one voxel entry of the store
  typedef struct packed {
    logic [47:0] dose_sum;
    logic [63:0] square_sum;
    logic [31:0] hit_count;
  } voxel_t;

endpackage
`default_nettype wire

### hw/rtl/vdt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdt_if
// Valid/ready channels of the voxel dose tally: input items and results.
// ----------------------------------------------------------------------------
interface vdt_in_if;
  import vdt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdt_out_if;
  import vdt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/voxel_dose_tally_core.sv
// Deposit steps: fetch, 33-step divider, square, write back.
// Readout steps: the bit-serial wide multiplier (one multiplier bit per cycle over up to
// four products), the 33-step divider and the 16-step root.
// One item is in flight at a time; the memory port serializes fetch and write back.
// After reset a clearing pass writes MAX_X*MAX_Y*MAX_Z entries, one a cycle
// (262144 entries at the defaults) while no item is taken; config writes still apply.
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_dose_tally_core
// Voxel store of dose sums, squared-dose sums and hit counts, with deposit
// scoring and readout of the relative standard deviation.
// ----------------------------------------------------------------------------
module voxel_dose_tally_core #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vdt_in_if.sink                            in_chan,
  vdt_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [vdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vdt_pkg::CFG_W-1:0]         cfg_data
);
  import vdt_pkg::*;

  localparam int NVOX     = MAX_X * MAX_Y * MAX_Z;
  localparam int AW       = (NVOX > 1) ? $clog2(NVOX) : 1;
  localparam int STRIDE_X = MAX_Y * MAX_Z;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NVOX - 1);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_LOAD  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_SQR   = 10'b0000100000,
    S_WB    = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ROOT  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  // multiply phases of a readout
  localparam logic [1:0] PH_NQ  = 2'd0;
  localparam logic [1:0] PH_SS  = 2'd1;
  localparam logic [1:0] PH_LIM = 2'd2;
  localparam logic [1:0] PH_DEN = 2'd3;

  state_t       state_r;
  logic [6:0]   vox_x_r, vox_y_r, vox_z_r;
  logic [31:0]  vol_r;
  in_item_t     item_r;
  voxel_t       vox_r;
  logic [47:0]  mass_r;
  logic [AW-1:0] clr_addr_r;

  // serial multiplier
  logic [127:0] acc_r, mc_r;
  logic [47:0]  mp_r;
  logic [1:0]   phase_r;
  logic [127:0] x_r;
  logic [95:0]  y_r;

  // restoring divider
  logic [127:0] rem_r;
  logic [159:0] dvs_r;
  logic [32:0]  quo_r;
  logic [5:0]   dcnt_r;

  // deposit results
  logic [31:0]  dose_r;
  logic         dose_sat_r;
  logic [63:0]  sq_r;

  // integer root
  logic [31:0]  root_v_r;
  logic [15:0]  root_r, rbit_r;

  out_item_t    res_r, out_data_r;
  logic         out_valid_r;

  // voxel memory
  voxel_t       mem [NVOX];
  voxel_t       rd_r;
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  voxel_t       mem_wdata;

  // address and range of the held item
  logic [31:0]  addr_full;
  logic [AW-1:0] vox_addr;
  logic         in_range;
  assign addr_full = 32'(item_r.x_index) * 32'(STRIDE_X)
                   + 32'(item_r.y_index) * 32'(MAX_Z) + 32'(item_r.z_index);
  assign vox_addr  = addr_full[AW-1:0];
  assign in_range  = ({1'b0, item_r.x_index} < vox_x_r) && (32'(item_r.x_index) < 32'(MAX_X))
                  && ({1'b0, item_r.y_index} < vox_y_r) && (32'(item_r.y_index) < 32'(MAX_Y))
                  && ({1'b0, item_r.z_index} < vox_z_r) && (32'(item_r.z_index) < 32'(MAX_Z));

  // divider step
  logic [159:0] rem_ext, rem_sub;
  logic         div_ge;
  logic [32:0]  quo_nxt;
  logic [31:0]  quo_clamp;
  assign rem_ext   = {32'b0, rem_r};
  assign div_ge    = rem_ext >= dvs_r;
  assign rem_sub   = rem_ext - dvs_r;
  assign quo_nxt   = {quo_r[31:0], div_ge};
  assign quo_clamp = quo_nxt[32] ? 32'hFFFF_FFFF : quo_nxt[31:0];

  // multiplier step
  logic [127:0] acc_nxt;
  assign acc_nxt = mp_r[0] ? (acc_r + mc_r) : acc_r;

  // root step
  logic [15:0]  trial;
  logic [31:0]  trial_sq;
  logic         trial_ok;
  assign trial    = root_r | rbit_r;
  assign trial_sq = 32'(trial) * 32'(trial);
  assign trial_ok = trial_sq <= root_v_r;

  // write-back sums
  logic [48:0]  dsum_nxt;
  logic [64:0]  qsum_nxt;
  logic         cnt_full;
  voxel_t       wb_vox;
  logic         wb_sat;
  assign dsum_nxt = {1'b0, vox_r.dose_sum} + 49'(dose_r);
  assign qsum_nxt = {1'b0, vox_r.square_sum} + {1'b0, sq_r};
  assign cnt_full = (vox_r.hit_count == 32'hFFFF_FFFF);
  always_comb begin
    wb_vox.dose_sum   = dsum_nxt[48] ? 48'hFFFF_FFFF_FFFF : dsum_nxt[47:0];
    wb_vox.square_sum = qsum_nxt[64] ? 64'hFFFF_FFFF_FFFF_FFFF : qsum_nxt[63:0];
    wb_vox.hit_count  = cnt_full ? vox_r.hit_count : vox_r.hit_count + 32'd1;
    wb_sat            = dose_sat_r || dsum_nxt[48] || qsum_nxt[64] || cnt_full;
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = vox_addr;
    mem_wdata = wb_vox;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      S_WB: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_r <= mem[mem_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vox_x_r <= VOXELS_RST;
      vox_y_r <= VOXELS_RST;
      vox_z_r <= VOXELS_RST;
      vol_r   <= VOLUME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOXELS_X:     vox_x_r <= cfg_data[6:0];
        REG_VOXELS_Y:     vox_y_r <= cfg_data[6:0];
        REG_VOXELS_Z:     vox_z_r <= cfg_data[6:0];
        REG_VOXEL_VOLUME: vol_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: set on emit, cleared once taken
      if (state_r == S_EMIT && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // zero the store one entry a cycle
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_ADDR) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            item_r  <= in_chan.data;
            res_r   <= '0;
            state_r <= S_FETCH;
          end
        end
        // memory read issued here; screen the item
        S_FETCH: begin
          mass_r <= 48'(vol_r) * 48'(item_r.density);
          if (item_r.func == FUNC_DEPOSIT
              && (item_r.energy_ev == 32'd0 || !item_r.in_scoring_volume)) begin
            res_r.status <= ST_IGNORED;
            state_r      <= S_EMIT;
          end else if (!in_range) begin
            res_r.status <= ST_RANGE;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          vox_r <= rd_r;
          if (item_r.func == FUNC_DEPOSIT) begin
            if (mass_r == 48'd0) begin
              res_r.status <= ST_NO_MASS;
              state_r      <= S_EMIT;
            end else begin
              rem_r   <= {80'b0, item_r.energy_ev, 16'b0};
              dvs_r   <= {80'b0, mass_r, 32'b0};
              quo_r   <= '0;
              dcnt_r  <= 6'd32;
              state_r <= S_DIV;
            end
          end else begin
            res_r.status          <= ST_OK;
            res_r.dose_sum        <= rd_r.dose_sum;
            res_r.dose_square_sum <= rd_r.square_sum;
            res_r.hit_count       <= rd_r.hit_count;
            if (rd_r.hit_count > 32'd1 && rd_r.dose_sum != 48'd0) begin
              acc_r   <= '0;
              mc_r    <= {64'b0, rd_r.square_sum};
              mp_r    <= {16'b0, rd_r.hit_count};
              phase_r <= PH_NQ;
              state_r <= S_MUL;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        // one quotient bit a cycle; the top bit flags a quotient of 2^32 or more
        S_DIV: begin
          if (div_ge) rem_r <= rem_sub[127:0];
          dvs_r  <= dvs_r >> 1;
          quo_r  <= quo_nxt;
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd0) begin
            if (item_r.func == FUNC_DEPOSIT) begin
              dose_r     <= quo_clamp;
              dose_sat_r <= quo_nxt[32];
              state_r    <= S_SQR;
            end else begin
              root_v_r <= quo_clamp;
              root_r   <= '0;
              rbit_r   <= 16'h8000;
              state_r  <= S_ROOT;
            end
          end
        end
        S_SQR: begin
          sq_r    <= 64'(dose_r) * 64'(dose_r);
          state_r <= S_WB;
        end
        S_WB: begin
          res_r.status <= wb_sat ? ST_SAT : ST_OK;
          state_r      <= S_EMIT;
        end
        // shift-add multiplier, one multiplier bit a cycle
        S_MUL: begin
          if (mp_r != 48'd0) begin
            acc_r <= acc_nxt;
            mc_r  <= mc_r << 1;
            mp_r  <= mp_r >> 1;
          end else begin
            acc_r <= '0;
            case (phase_r)
              PH_NQ: begin
                x_r     <= {32'b0, acc_r[95:0]};
                mc_r    <= {80'b0, vox_r.dose_sum};
                mp_r    <= vox_r.dose_sum;
                phase_r <= PH_SS;
              end
              PH_SS: begin
                y_r <= acc_r[95:0];
                if (x_r[95:0] <= acc_r[95:0]) begin
                  res_r.deviation_valid <= 1'b1;
                  state_r               <= S_EMIT;
                end else begin
                  x_r     <= {32'b0, x_r[95:0] - acc_r[95:0]};
                  mc_r    <= {32'b0, x_r[95:0] - acc_r[95:0]};
                  mp_r    <= RSD_SCALE;
                  phase_r <= PH_LIM;
                end
              end
              PH_LIM: begin
                x_r     <= acc_r << RSD_SHIFT;
                mc_r    <= {32'b0, y_r};
                mp_r    <= {16'b0, vox_r.hit_count - 32'd1};
                phase_r <= PH_DEN;
              end
              PH_DEN: begin
                rem_r   <= x_r;
                dvs_r   <= {acc_r, 32'b0};
                quo_r   <= '0;
                dcnt_r  <= 6'd32;
                state_r <= S_DIV;
              end
              default: ;
            endcase
          end
        end
        // integer square root, one result bit a cycle
        S_ROOT: begin
          if (trial_ok) root_r <= trial;
          rbit_r <= rbit_r >> 1;
          if (rbit_r[0]) begin
            res_r.relative_deviation <= trial_ok ? trial : root_r;
            res_r.deviation_valid    <= 1'b1;
            state_r                  <= S_EMIT;
          end
        end
        // hand the result to the output register
        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // no item taken while the store is being cleared
  a_clr_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_chan.ready)
    else $error("item accepted during clearing pass");

  // an accepted item goes straight to the fetch step
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_FETCH))
    else $error("accepted item not fetched");

  // the partial root never overshoots its operand
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (32'(root_r) * 32'(root_r) <= root_v_r))
    else $error("square root partial result too large");

endmodule
`default_nettype wire
